FILE: design/gptu_pkg.sv
// ----------------------------------------------------------------------------
// gptu_pkg
// Shared types and constants for the packed-mode graphics tag unpacker:
// channel payloads, queue entry and register descriptor codes.
// ----------------------------------------------------------------------------
package gptu_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register descriptor codes
    localparam logic [3:0] DESC_PRIM  = 4'h0;
    localparam logic [3:0] DESC_RGBAQ = 4'h1;
    localparam logic [3:0] DESC_ST    = 4'h2;
    localparam logic [3:0] DESC_UV    = 4'h3;
    localparam logic [3:0] DESC_XYZF2 = 4'h4;
    localparam logic [3:0] DESC_XYZ2  = 4'h5;
    localparam logic [3:0] DESC_FOG   = 4'hA;
    localparam logic [3:0] DESC_AD    = 4'hE;
    localparam logic [3:0] DESC_NOP   = 4'hF;

    // Kick-free vertex register addresses
    localparam logic [7:0] ADDR_XYZF3 = 8'h0C;
    localparam logic [7:0] ADDR_XYZ3  = 8'h0D;

    // Register count when the tag's NREG field is zero
    localparam logic [4:0] NREG_FULL = 5'd16;

    // Input item: one quadword plus the range-end marker
    typedef struct packed {
        logic [31:0] qw_word0;
        logic [31:0] qw_word1;
        logic [31:0] qw_word2;
        logic [31:0] qw_word3;
        logic        range_last;
    } gptu_in_t;

    // Result item: one register write
    typedef struct packed {
        logic [7:0]  reg_addr;
        logic [63:0] reg_data;
    } gptu_out_t;

    // Classified work handed from front to back
    typedef struct packed {
        logic [3:0]  desc;   // format to apply, NOP for none
        logic [31:0] a0;
        logic [31:0] a1;
        logic [31:0] b0;
        logic [31:0] b1;
        logic        clr;    // range end: clear Q after this item
    } gptu_cmd_t;

endpackage

FILE: design/gif_packed_tag_unpacker.sv
// The queue takes each item at the edge that accepts it, and the output
// register takes it from the queue head when that register is empty or taken.
// Throughput: one quadword per cycle; the front accepts whenever the command
// queue has room, and the back drains one command per cycle while its output
// register is free; a result held by m_ready stalls only once the queue fills.
// Reset (aresetn low, synchronous): decoder expects a tag, queue empty, Q zero.
// ----------------------------------------------------------------------------
// gif_packed_tag_unpacker
// Packed-mode graphics tag unpacker: turns tag and data quadwords into
// register writes through a classify front, a command queue and a format back.
// ----------------------------------------------------------------------------
module gif_packed_tag_unpacker #(
    parameter int FIFO_DEPTH = gptu_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gptu_pkg::gptu_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output gptu_pkg::gptu_out_t m_item
);
    import gptu_pkg::*;

    logic      q_push, q_pop, q_full, q_empty;
    gptu_cmd_t push_cmd, head_cmd;

    gptu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    gptu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .empty    (q_empty),
        .pop      (q_pop),
        .head_cmd (head_cmd)
    );

    gptu_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

FILE: design/gptu_front.sv
// ----------------------------------------------------------------------------
// gptu_front
// Accepts quadwords, tracks tag/data/stop decoding and the loop position,
// and classifies each item into a command for the formatting stage.
// ----------------------------------------------------------------------------
module gptu_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gptu_pkg::gptu_in_t  s_item,
    input  logic                q_full,
    output logic                q_push,
    output gptu_pkg::gptu_cmd_t q_cmd
);
    import gptu_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_DATA = 2'd1,
        PH_STOP = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [14:0] loops_reg, loops_next;
    logic [4:0]  count_reg, count_next;
    logic [3:0]  slot_reg, slot_next;
    logic [63:0] descs_reg, descs_next;
    logic        eop_reg, eop_next;

    // Tag fields
    logic [14:0] tag_nloop;
    logic        tag_eop;
    logic        tag_pre;
    logic [10:0] tag_prim;
    logic [1:0]  tag_flg;
    logic [3:0]  tag_nreg;
    logic [4:0]  slot_inc;
    logic [14:0] loops_dec;

    assign tag_nloop = s_item.qw_word0[14:0];
    assign tag_eop   = s_item.qw_word0[15];
    assign tag_pre   = s_item.qw_word1[14];
    assign tag_prim  = s_item.qw_word1[25:15];
    assign tag_flg   = s_item.qw_word1[27:26];
    assign tag_nreg  = s_item.qw_word1[31:28];
    assign slot_inc  = {1'b0, slot_reg} + 5'd1;
    assign loops_dec = loops_reg - 15'd1;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Classify item and compute next decode state
    always_comb begin
        phase_next = phase_reg;
        loops_next = loops_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        descs_next = descs_reg;
        eop_next   = eop_reg;

        q_cmd.desc = DESC_NOP;
        q_cmd.a0   = s_item.qw_word0;
        q_cmd.a1   = s_item.qw_word1;
        q_cmd.b0   = s_item.qw_word2;
        q_cmd.b1   = s_item.qw_word3;
        q_cmd.clr  = s_item.range_last;

        case (phase_reg)
            PH_TAG: begin
                if (tag_flg != 2'd0) begin
                    phase_next = PH_STOP;
                end else begin
                    count_next = (tag_nreg == 4'd0) ? NREG_FULL : {1'b0, tag_nreg};
                    descs_next = {s_item.qw_word3, s_item.qw_word2};
                    eop_next   = tag_eop;
                    slot_next  = 4'd0;
                    loops_next = tag_nloop;
                    if (tag_pre) begin
                        q_cmd.desc = DESC_PRIM;
                        q_cmd.a0   = {21'd0, tag_prim};
                    end
                    if (tag_nloop != 15'd0) begin
                        phase_next = PH_DATA;
                    end else begin
                        phase_next = tag_eop ? PH_STOP : PH_TAG;
                    end
                end
            end
            PH_DATA: begin
                q_cmd.desc = descs_reg[slot_reg*4 +: 4];
                if (slot_inc >= count_reg) begin
                    slot_next  = 4'd0;
                    loops_next = loops_dec;
                    if (loops_dec == 15'd0) begin
                        phase_next = eop_reg ? PH_STOP : PH_TAG;
                    end
                end else begin
                    slot_next = slot_inc[3:0];
                end
            end
            default: begin
                // stopped: wait for range end
            end
        endcase

        if (s_item.range_last) begin
            phase_next = PH_TAG;
            loops_next = 15'd0;
            count_next = NREG_FULL;
            slot_next  = 4'd0;
            descs_next = 64'd0;
            eop_next   = 1'b0;
        end
    end

    // Decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TAG;
            loops_reg <= 15'd0;
            count_reg <= NREG_FULL;
            slot_reg  <= 4'd0;
            descs_reg <= 64'd0;
            eop_reg   <= 1'b0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            loops_reg <= loops_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            descs_reg <= descs_next;
            eop_reg   <= eop_next;
        end
    end

    // Data phase always has loops left to run
    a_data_has_loops: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> loops_reg != 15'd0)
        else $error("data phase with zero loops left");

    // Register count stays within 1..16
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 5'd0 && count_reg <= NREG_FULL)
        else $error("register count out of range");

endmodule

FILE: design/gptu_fifo.sv
// ----------------------------------------------------------------------------
// gptu_fifo
// Short command queue that decouples the classifying front from the
// formatting back.
// ----------------------------------------------------------------------------
module gptu_fifo #(
    parameter int DEPTH = gptu_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  gptu_pkg::gptu_cmd_t push_cmd,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output gptu_pkg::gptu_cmd_t head_cmd
);
    import gptu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gptu_cmd_t         mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

endmodule

FILE: design/gptu_back.sv
// ----------------------------------------------------------------------------
// gptu_back
// Formats queued commands into register writes, keeps the Q latch and
// holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module gptu_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  gptu_pkg::gptu_cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output gptu_pkg::gptu_out_t m_item
);
    import gptu_pkg::*;

    logic        m_valid_reg, m_valid_next;
    gptu_out_t   m_item_reg, m_item_next;
    logic [31:0] q_latch_reg, q_latch_next;
    logic        has_res;
    logic [7:0]  addr;
    logic [63:0] data;
    logic [31:0] xy;

    assign q_pop   = !q_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign xy      = {q_cmd.a1[15:0], q_cmd.a0[15:0]};

    // Format by descriptor
    always_comb begin
        has_res = 1'b1;
        addr    = {4'd0, q_cmd.desc};
        data    = {q_cmd.a1, q_cmd.a0};
        case (q_cmd.desc)
            DESC_PRIM:  data = {53'd0, q_cmd.a0[10:0]};
            DESC_RGBAQ: data = {q_latch_reg, q_cmd.b1[7:0], q_cmd.b0[7:0],
                                q_cmd.a1[7:0], q_cmd.a0[7:0]};
            DESC_ST:    data = {q_cmd.a1, q_cmd.a0};
            DESC_UV:    data = {34'd0, q_cmd.a1[13:0], 2'd0, q_cmd.a0[13:0]};
            DESC_XYZF2: begin
                addr = q_cmd.b1[15] ? ADDR_XYZF3 : {4'd0, DESC_XYZF2};
                data = {q_cmd.b1[11:4], q_cmd.b0[27:4], xy};
            end
            DESC_XYZ2: begin
                addr = q_cmd.b1[15] ? ADDR_XYZ3 : {4'd0, DESC_XYZ2};
                data = {q_cmd.b0, xy};
            end
            DESC_FOG:   data = {q_cmd.b1[11:4], 56'd0};
            DESC_AD:    addr = q_cmd.b0[7:0];
            DESC_NOP:   has_res = 1'b0;
            default: begin
                // raw write to the descriptor's address
            end
        endcase
    end

    // Output register and Q latch update
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        q_latch_next = q_latch_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            m_valid_next = has_res;
            if (has_res) begin
                m_item_next.reg_addr = addr;
                m_item_next.reg_data = data;
            end
            if (q_cmd.clr) begin
                q_latch_next = 32'd0;
            end else if (q_cmd.desc == DESC_ST) begin
                q_latch_next = q_cmd.b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            q_latch_reg <= 32'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            q_latch_reg <= q_latch_next;
        end
        m_item_reg <= m_item_next;
    end

    // Range end leaves Q cleared
    a_clr_q: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_cmd.clr |=> q_latch_reg == 32'd0)
        else $error("Q latch not cleared at range end");

    // Q only changes when a command is taken
    a_q_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_pop |=> $stable(q_latch_reg))
        else $error("Q latch changed without a command");

endmodule
